// File: rtl/yuvrgb_pkg.sv
package yuvrgb_pkg;

	// input pixel, luma in the low byte
	typedef struct packed {
		logic [7:0] chroma_red;
		logic [7:0] chroma_blue;
		logic [7:0] luma;
	} yuv_t;

	// output pixel, red in the low byte
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	localparam int ProdW = 18;
	localparam int OffW  = 10;
	localparam int SumW  = 11;

	localparam logic signed [8:0]       ChromaCenter = 9'sd128;
	localparam logic signed [ProdW-1:0] KRedV        = 18'sd351;
	localparam logic signed [ProdW-1:0] KGreenV      = 18'sd179;
	localparam logic signed [ProdW-1:0] KGreenU      = 18'sd86;
	localparam logic signed [ProdW-1:0] KBlueU       = 18'sd444;
	localparam logic signed [ProdW-1:0] RoundBias    = 18'sd255;
	localparam logic [7:0]              ChanMax      = 8'd255;
	localparam logic [7:0]              AlphaOpaque  = 8'd255;

	// divide by 256, truncating toward zero
	function automatic logic signed [OffW-1:0] div256_trunc(input logic signed [ProdW-1:0] v);
		logic signed [ProdW-1:0] biased;
		logic signed [ProdW-1:0] shifted;
		biased  = v[ProdW-1] ? (v + RoundBias) : v;
		shifted = biased >>> 8;
		return shifted[OffW-1:0];
	endfunction

	// saturate a signed channel sum to 0..255
	function automatic logic [7:0] clamp8(input logic signed [SumW-1:0] s);
		logic [7:0] r;
		if (s[SumW-1]) begin
			r = 8'd0;
		end else if (s > $signed({3'b000, ChanMax})) begin
			r = ChanMax;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/yuvrgb_calc.sv
module yuvrgb_calc (
	input  yuvrgb_pkg::yuv_t  yuv,
	output yuvrgb_pkg::rgba_t rgba
);

	logic signed [8:0]                     uc;
	logic signed [8:0]                     vc;
	logic signed [yuvrgb_pkg::ProdW-1:0]   uc_w;
	logic signed [yuvrgb_pkg::ProdW-1:0]   vc_w;
	logic signed [yuvrgb_pkg::ProdW-1:0]   prod_rv;
	logic signed [yuvrgb_pkg::ProdW-1:0]   prod_gv;
	logic signed [yuvrgb_pkg::ProdW-1:0]   prod_gu;
	logic signed [yuvrgb_pkg::ProdW-1:0]   prod_bu;
	logic signed [yuvrgb_pkg::OffW-1:0]    off_r;
	logic signed [yuvrgb_pkg::OffW-1:0]    off_g;
	logic signed [yuvrgb_pkg::OffW-1:0]    off_b;
	logic signed [yuvrgb_pkg::SumW-1:0]    y_w;
	logic signed [yuvrgb_pkg::SumW-1:0]    sum_r;
	logic signed [yuvrgb_pkg::SumW-1:0]    sum_g;
	logic signed [yuvrgb_pkg::SumW-1:0]    sum_b;

	// center chroma around zero
	assign uc   = $signed({1'b0, yuv.chroma_blue}) - yuvrgb_pkg::ChromaCenter;
	assign vc   = $signed({1'b0, yuv.chroma_red}) - yuvrgb_pkg::ChromaCenter;
	assign uc_w = yuvrgb_pkg::ProdW'(uc);
	assign vc_w = yuvrgb_pkg::ProdW'(vc);

	// constant multiplies
	assign prod_rv = vc_w * yuvrgb_pkg::KRedV;
	assign prod_gv = vc_w * yuvrgb_pkg::KGreenV;
	assign prod_gu = uc_w * yuvrgb_pkg::KGreenU;
	assign prod_bu = uc_w * yuvrgb_pkg::KBlueU;

	// each term truncated on its own, green divides the negated V product and subtracts the U term
	assign off_r = yuvrgb_pkg::div256_trunc(prod_rv);
	assign off_g = yuvrgb_pkg::div256_trunc(-prod_gv) - yuvrgb_pkg::div256_trunc(prod_gu);
	assign off_b = yuvrgb_pkg::div256_trunc(prod_bu);

	assign y_w   = $signed({3'b000, yuv.luma});
	assign sum_r = y_w + yuvrgb_pkg::SumW'(off_r);
	assign sum_g = y_w + yuvrgb_pkg::SumW'(off_g);
	assign sum_b = y_w + yuvrgb_pkg::SumW'(off_b);

	assign rgba.red   = yuvrgb_pkg::clamp8(sum_r);
	assign rgba.green = yuvrgb_pkg::clamp8(sum_g);
	assign rgba.blue  = yuvrgb_pkg::clamp8(sum_b);
	assign rgba.alpha = yuvrgb_pkg::AlphaOpaque;

endmodule

// File: rtl/yuv_to_rgba_pixel_convert.sv
// yuv to rgba pixel converter, one pixel per beat
// a beat passes the input register, then the result register, to the master side
// throughput: one pixel per clock cycle while the master side takes every beat
// the input register and the result register each advance whenever the stage after is free
// reset: arst_n low clears both stage valid flags at once; payload registers are not reset
module yuv_to_rgba_pixel_convert (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
	input  logic        s_tlast,  // frame_end
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
	output logic        m_tlast   // frame_end_out
);

	// stage 1: registered input pixel
	logic              valid_s1;
	yuvrgb_pkg::yuv_t  yuv_s1;
	logic              last_s1;

	// stage 2: registered result pixel
	logic              valid_s2;
	yuvrgb_pkg::rgba_t rgba_s2;
	logic              last_s2;

	logic              adv1;
	logic              adv2;
	yuvrgb_pkg::rgba_t rgba_calc;

	// stage 2 can load when it is empty or its beat is being taken this cycle
	assign adv2 = !valid_s2 || m_tready;
	// stage 1 can load when it is empty or its pixel moves on into stage 2
	assign adv1 = !valid_s1 || adv2;

	assign s_tready = adv1;

	// conversion between the two registers
	yuvrgb_calc u_calc (
		.yuv  (yuv_s1),
		.rgba (rgba_calc)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload, loaded only on a real beat so a stalled result holds
	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			yuv_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv2 && valid_s1) begin
			rgba_s2 <= rgba_calc;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = rgba_s2;
	assign m_tlast  = last_s2;

endmodule

// File: test/yuv_to_rgba_pixel_convert_chk.sv
`timescale 1ns / 100ps

// watches both sides of the converter, predicts each rgba beat and compares
module yuv_to_rgba_pixel_convert_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
	input  logic        s_tlast,  // frame_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
	input  logic        m_tlast,  // frame_end_out
	output int          fail_count,
	output int          pending
);

	localparam int ChromaMid = 128;
	localparam int ScaleDiv  = 256;
	localparam int ChanTop   = 255;

	typedef struct {
		yuvrgb_pkg::rgba_t pix;
		logic              last;
	} rgba_beat_t;

	rgba_beat_t rgba_q[$];
	int mism_count = 0;
	int backlog    = 0;

	assign fail_count = mism_count;
	assign pending    = backlog;

	function automatic logic [7:0] sat_channel(input int v);
		if (v < 0) return 8'd0;
		if (v > ChanTop) return 8'd255;
		return v[7:0];
	endfunction

	// int division truncates toward zero, same as the conversion wants
	function automatic rgba_beat_t convert_pixel(input yuvrgb_pkg::yuv_t px, input logic last);
		rgba_beat_t b;
		int y, uc, vc, off_r, off_g, off_b;
		y     = int'(px.luma);
		uc    = int'(px.chroma_blue) - ChromaMid;
		vc    = int'(px.chroma_red) - ChromaMid;
		off_r = (351 * vc) / ScaleDiv;
		off_g = (-(179 * vc)) / ScaleDiv - (86 * uc) / ScaleDiv;
		off_b = (444 * uc) / ScaleDiv;
		b.pix.red   = sat_channel(y + off_r);
		b.pix.green = sat_channel(y + off_g);
		b.pix.blue  = sat_channel(y + off_b);
		b.pix.alpha = 8'd255;
		b.last      = last;
		return b;
	endfunction

	task automatic flag_mismatch(input string what, input int want, input int got);
		mism_count++;
		if (mism_count <= 10) begin
			$display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rgba_beat_t        want;
		yuvrgb_pkg::rgba_t got;
		if (!arst_n) begin
			rgba_q.delete();
			backlog <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = yuvrgb_pkg::rgba_t'(m_tdata);
				if (rgba_q.size() == 0) begin
					flag_mismatch("unexpected beat", 0, int'(m_tdata));
				end else begin
					want = rgba_q.pop_front();
					if (got.red !== want.pix.red)
						flag_mismatch("red", want.pix.red, got.red);
					if (got.green !== want.pix.green)
						flag_mismatch("green", want.pix.green, got.green);
					if (got.blue !== want.pix.blue)
						flag_mismatch("blue", want.pix.blue, got.blue);
					if (got.alpha !== want.pix.alpha)
						flag_mismatch("alpha", want.pix.alpha, got.alpha);
					if (m_tlast !== want.last)
						flag_mismatch("tlast", want.last, m_tlast);
				end
			end
			if (s_tvalid && s_tready) begin
				rgba_q.push_back(convert_pixel(yuvrgb_pkg::yuv_t'(s_tdata), s_tlast));
			end
			backlog <= rgba_q.size();
		end
	end

endmodule

// File: test/yuv_to_rgba_pixel_convert_tb.sv
`timescale 1ns / 100ps

// stimulus and verdict for the yuv to rgba converter; checking lives in the checker
module yuv_to_rgba_pixel_convert_tb;

	localparam int RandPixels = 1100;
	localparam int CycleLimit = 400000;
	localparam int PhaseLen   = 150;     // pixels per phase
	localparam int DrainEvery = 275;     // pixels between full drains

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
	logic        s_tlast  = 1'b0;  // frame_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
	logic        m_tlast;  // frame_end_out

	int fail_count;
	int pending;
	int cycles    = 0;
	int sink_hold = 0;
	bit calm_run  = 1'b0;  // no new idling on either side while set

	// corner pixels: {frame_end, chroma_red, chroma_blue, luma}
	logic [24:0] corner_px [18] = '{
		{1'b0, 8'd0,   8'd0,   8'd0},    // all zero
		{1'b0, 8'd255, 8'd255, 8'd255},  // all ones
		{1'b1, 8'd255, 8'd255, 8'd0},
		{1'b0, 8'd0,   8'd0,   8'd255},
		{1'b0, 8'd128, 8'd128, 8'd0},    // neutral chroma, grey ramp ends
		{1'b0, 8'd128, 8'd128, 8'd255},
		{1'b0, 8'd128, 8'd128, 8'd128},
		{1'b0, 8'd129, 8'd129, 8'd100},  // tiny positive chroma
		{1'b0, 8'd127, 8'd127, 8'd100},  // tiny negative, truncation toward zero
		{1'b0, 8'd0,   8'd255, 8'd128},
		{1'b1, 8'd255, 8'd0,   8'd128},
		{1'b0, 8'd255, 8'd128, 8'd200},  // red saturates high
		{1'b0, 8'd0,   8'd128, 8'd50},   // red saturates low
		{1'b0, 8'd128, 8'd255, 8'd200},  // blue saturates high
		{1'b0, 8'd128, 8'd0,   8'd50},   // blue saturates low
		{1'b1, 8'd0,   8'd0,   8'd200},  // green saturates high
		{1'b0, 8'd255, 8'd255, 8'd20},   // green saturates low
		{1'b1, 8'd0,   8'd255, 8'd200}
	};

	yuv_to_rgba_pixel_convert u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	yuv_to_rgba_pixel_convert_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// chroma and luma bytes leaning toward the ends and the center
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'd255;
		if (r == 2) return 8'($urandom_range(126, 130));
		return 8'($urandom_range(0, 255));
	endfunction

	// receiver backpressure, one assignment per edge
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_tready  <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (!calm_run && $urandom_range(0, 99) < 30) begin
			m_tready  <= 1'b0;
			sink_hold <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("yuv_to_rgba_pixel_convert_tb failed");
			$finish;
		end
	end

	// offer one beat, hold until taken, then maybe idle
	task automatic send_pixel(input yuvrgb_pkg::yuv_t px, input logic last);
		int idle;
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		idle = calm_run ? 0 : pick_gap();
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
	endtask

	// sender holds off until the checker has seen every pixel come back
	task automatic drain_pause();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		yuvrgb_pkg::yuv_t px;
		int               i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		for (i = 0; i < 18; i++) begin
			send_pixel(yuvrgb_pkg::yuv_t'(corner_px[i][23:0]), corner_px[i][24]);
		end

		// random pixels in phases, every third phase without idling
		for (i = 0; i < RandPixels; i++) begin
			if (i % PhaseLen == 0) calm_run <= ((i / PhaseLen) % 3 == 1);
			if (i % DrainEvery == DrainEvery - 1) drain_pause();
			px.luma        = pick_byte();
			px.chroma_blue = pick_byte();
			px.chroma_red  = pick_byte();
			// replicate chroma over short runs like a 2x2 block would
			if (i % 4 != 0 && $urandom_range(0, 1) == 1) begin
				px.chroma_blue = s_tdata[15:8];
				px.chroma_red  = s_tdata[23:16];
			end
			send_pixel(px, $urandom_range(0, 7) == 0);
		end
		s_tvalid <= 1'b0;

		// wait for the pipeline to empty, then keep watching for strays
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("yuv_to_rgba_pixel_convert_tb passed");
		end else begin
			$display("yuv_to_rgba_pixel_convert_tb failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/yuvrgb_pkg.sv
rtl/yuvrgb_calc.sv
rtl/yuv_to_rgba_pixel_convert.sv
test/yuv_to_rgba_pixel_convert_chk.sv
test/yuv_to_rgba_pixel_convert_tb.sv
